// ===== rtl/core/sbfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbfr_pkg
// Types and constants shared by the frame receiver and scaler modules.
// ----------------------------------------------------------------------------
package sbfr_pkg;

	localparam int FRAME_BYTES = 25;
	localparam int DATA_BYTES  = 22;
	localparam int NUM_CH      = 16;
	localparam int RAW_W       = 11;
	localparam int VAL_W       = 12;
	localparam int GAIN_W      = 16;
	localparam int FRAC_W      = 12;
	localparam int PROD_W      = 29;
	localparam int SUM_W       = 30;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	localparam logic [7:0] HDR_BYTE  = 8'h0F;
	localparam logic [7:0] FOOT_BYTE = 8'h00;
	localparam logic [3:0] FOOT_NIB  = 4'h4;

	localparam logic [2:0] REG_RAW_CENTER = 3'd0;
	localparam logic [2:0] REG_SCALE_GAIN = 3'd1;
	localparam logic [2:0] REG_OUT_CENTER = 3'd2;
	localparam logic [2:0] REG_OUT_MAX    = 3'd3;
	localparam logic [2:0] REG_OUT_MIN    = 3'd4;

	localparam logic [RAW_W-1:0]  RAW_CENTER_RST = 11'd992;
	localparam logic [GAIN_W-1:0] SCALE_GAIN_RST = 16'd2560;
	localparam logic [VAL_W-1:0]  OUT_CENTER_RST = 12'd1500;
	localparam logic [VAL_W-1:0]  OUT_MAX_RST    = 12'd2000;
	localparam logic [VAL_W-1:0]  OUT_MIN_RST    = 12'd1000;

	localparam logic [3:0] LAST_CH = 4'd15;

	typedef logic [DATA_BYTES*8-1:0] frame_t;

	typedef struct packed {
		logic [RAW_W-1:0]  raw_center;
		logic [GAIN_W-1:0] scale_gain;
		logic [VAL_W-1:0]  out_center;
		logic [VAL_W-1:0]  out_max;
		logic [VAL_W-1:0]  out_min;
	} cfg_t;

	typedef struct packed {
		logic   push;
		frame_t data;
	} frame_beat_t;

	function automatic logic footer_ok(input logic [7:0] b);
		return (b == FOOT_BYTE) || (b[3:0] == FOOT_NIB);
	endfunction

endpackage

// ===== rtl/core/sbfr_front.sv =====
// ----------------------------------------------------------------------------
// sbfr_front
// Byte hunter: finds the header, collects the channel bytes, checks the
// footer and hands each good frame to the frame queue.
// ----------------------------------------------------------------------------
module sbfr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         rx_byte,
	output sbfr_pkg::frame_beat_t frame_beat
);
	import sbfr_pkg::*;

	logic [4:0] pos_q;
	logic [7:0] prev_q;
	frame_t     data_q;
	logic       last_byte;

	assign last_byte = (pos_q == 5'(FRAME_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			prev_q <= FOOT_BYTE;
		end else if (accept) begin
			prev_q <= rx_byte;
			if (pos_q == '0) begin
				if (rx_byte == HDR_BYTE && footer_ok(prev_q)) begin
					pos_q <= 5'd1;
				end
			end else if (pos_q < 5'(FRAME_BYTES)) begin
				pos_q <= last_byte ? '0 : pos_q + 5'd1;
			end else begin
				pos_q <= '0;
			end
		end
	end

	// channel bytes shift in, first one ends at the low end
	always_ff @(posedge clk) begin
		if (accept && pos_q != '0 && pos_q <= 5'(DATA_BYTES)) begin
			data_q <= {rx_byte, data_q[DATA_BYTES*8-1:8]};
		end
	end

	assign frame_beat.push = accept && last_byte && footer_ok(rx_byte);
	assign frame_beat.data = data_q;

endmodule

// ===== rtl/core/sbfr_frame_q.sv =====
// ----------------------------------------------------------------------------
// sbfr_frame_q
// Two-entry queue of decoded frames between the hunter and the scaler.
// ----------------------------------------------------------------------------
module sbfr_frame_q (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sbfr_pkg::frame_beat_t frame_beat,
	input  logic                  pop,
	output logic                  full,
	output logic                  nonempty,
	output sbfr_pkg::frame_t      head
);
	import sbfr_pkg::*;

	frame_t     slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (frame_beat.push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'(frame_beat.push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (frame_beat.push) begin
			slot_q[wr_q] <= frame_beat.data;
		end
	end

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign head     = slot_q[rd_q];

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !frame_beat.push)
		else $error("frame pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("frame popped from empty queue");

endmodule

// ===== rtl/core/sbfr_back.sv =====
// ----------------------------------------------------------------------------
// sbfr_back
// Channel scaler: walks the sixteen channels of the head frame, multiplies
// the centered raw value by the gain, adds the output center and clamps into the output register.
// ----------------------------------------------------------------------------
module sbfr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sbfr_pkg::cfg_t                cfg,
	input  logic                          frame_nonempty,
	input  sbfr_pkg::frame_t              frame_head,
	output logic                          frame_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic [3:0]                    channel_index,
	output logic [sbfr_pkg::VAL_W-1:0]    channel_value,
	output logic                          last_channel
);
	import sbfr_pkg::*;

	logic [3:0]               ch_q;
	logic                     v_s1;
	logic [3:0]               idx_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     out_v_q;
	logic [3:0]               out_idx_q;
	logic [VAL_W-1:0]         out_val_q;

	logic                     adv_out;
	logic                     adv_s1;
	logic                     issue;
	logic [RAW_W-1:0]         raw;
	logic signed [RAW_W:0]    diff;
	logic signed [SUM_W-1:0]  sum;
	logic [SUM_W-FRAC_W-2:0]  whole;
	logic [SUM_W-FRAC_W-2:0]  capped;
	logic [VAL_W-1:0]         result;

	assign adv_out   = !out_v_q || pop;
	assign adv_s1    = !v_s1 || adv_out;
	assign issue     = frame_nonempty && adv_s1;
	assign frame_pop = issue && (ch_q == LAST_CH);

	always_comb begin
		raw = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			if (ch_q == 4'(i)) begin
				raw = frame_head[i*RAW_W +: RAW_W];
			end
		end
		diff = $signed({1'b0, raw}) - $signed({1'b0, cfg.raw_center});
	end

	always_comb begin
		sum    = SUM_W'(prod_s1) + $signed(SUM_W'({cfg.out_center, {FRAC_W{1'b0}}}));
		whole  = sum[SUM_W-2:FRAC_W];
		capped = (whole > (SUM_W-FRAC_W-1)'(cfg.out_max)) ?
			(SUM_W-FRAC_W-1)'(cfg.out_max) : whole;
		if (sum[SUM_W-1] || capped < (SUM_W-FRAC_W-1)'(cfg.out_min)) begin
			result = cfg.out_min;
		end else begin
			result = capped[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q    <= '0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (issue) begin
				ch_q <= ch_q + 4'd1;
			end
			if (adv_s1) begin
				v_s1 <= issue;
			end
			if (adv_out) begin
				out_v_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= ch_q;
			prod_s1 <= PROD_W'(diff) * PROD_W'($signed({1'b0, cfg.scale_gain}));
		end
		if (adv_out && v_s1) begin
			out_idx_q <= idx_s1;
			out_val_q <= result;
		end
	end

	assign empty         = !out_v_q;
	assign channel_index = out_idx_q;
	assign channel_value = out_val_q;
	assign last_channel  = (out_idx_q == LAST_CH);

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		frame_pop |=> (ch_q == '0) && v_s1 && (idx_s1 == LAST_CH))
		else $error("frame released before its last channel");

	a_above_min: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> channel_value >= cfg.out_min)
		else $error("channel value below lower clamp");

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) ##1 !empty |-> channel_index == $past(channel_index) + 4'd1)
		else $error("channel beats out of order");

endmodule

// ===== rtl/core/sbus_frame_receiver_scaler_top.sv =====
// ----------------------------------------------------------------------------
// sbus_frame_receiver_scaler_top
// Receives serial bytes, decodes 25-byte frames and emits sixteen scaled
// channel values per good frame.
// ----------------------------------------------------------------------------
// a good frame is written to the frame queue; each channel then passes the product and output registers
// throughput: one byte per cycle while full is low; a frame drains at one channel beat per cycle while pop keeps pace
// full rises only while two decoded frames wait in the frame queue
// reset: hunting for a header, previous byte 0x00, registers at their defaults
// no clearing pass; the frame buffer is filled before any read
module sbus_frame_receiver_scaler_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sbfr_pkg::ADDR_W-1:0]    paddr,
	input  logic [sbfr_pkg::DATA_W-1:0]    pwdata,
	output logic [sbfr_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     rx_byte,
	output logic                           empty,
	input  logic                           pop,
	output logic [3:0]                     channel_index,
	output logic [sbfr_pkg::VAL_W-1:0]     channel_value,
	output logic                           last_channel
);
	import sbfr_pkg::*;

	cfg_t        cfg_q;
	frame_beat_t frame_beat;
	frame_t      frame_head;
	logic        frame_pop;
	logic        frame_nonempty;
	logic        accept;
	logic [2:0]  reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1:2];
	assign accept  = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raw_center <= RAW_CENTER_RST;
			cfg_q.scale_gain <= SCALE_GAIN_RST;
			cfg_q.out_center <= OUT_CENTER_RST;
			cfg_q.out_max    <= OUT_MAX_RST;
			cfg_q.out_min    <= OUT_MIN_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_RAW_CENTER: cfg_q.raw_center <= pwdata[RAW_W-1:0];
				REG_SCALE_GAIN: cfg_q.scale_gain <= pwdata[GAIN_W-1:0];
				REG_OUT_CENTER: cfg_q.out_center <= pwdata[VAL_W-1:0];
				REG_OUT_MAX:    cfg_q.out_max    <= pwdata[VAL_W-1:0];
				REG_OUT_MIN:    cfg_q.out_min    <= pwdata[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_RAW_CENTER: prdata = DATA_W'(cfg_q.raw_center);
			REG_SCALE_GAIN: prdata = DATA_W'(cfg_q.scale_gain);
			REG_OUT_CENTER: prdata = DATA_W'(cfg_q.out_center);
			REG_OUT_MAX:    prdata = DATA_W'(cfg_q.out_max);
			REG_OUT_MIN:    prdata = DATA_W'(cfg_q.out_min);
			default:        prdata = '0;
		endcase
	end

	sbfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.frame_beat (frame_beat)
	);

	sbfr_frame_q u_frame_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_beat (frame_beat),
		.pop        (frame_pop),
		.full       (full),
		.nonempty   (frame_nonempty),
		.head       (frame_head)
	);

	sbfr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.frame_nonempty (frame_nonempty),
		.frame_head     (frame_head),
		.frame_pop      (frame_pop),
		.pop            (pop),
		.empty          (empty),
		.channel_index  (channel_index),
		.channel_value  (channel_value),
		.last_channel   (last_channel)
	);

endmodule
